/* design/mpcr_pkg.sv */
// shared types and constants for the midpoint circle rasterizer
package mpcr_pkg;

  // field widths
  localparam int COORD_BITS_DEF = 12;
  localparam int OFF_W          = 12;
  localparam int RAD_W          = 11;
  localparam int DEC_W          = 16;
  localparam int COLOR_W        = 32;
  localparam int DIM_W          = 13;
  localparam int SCR_W          = 14;
  localparam int IDX_W          = 3;

  typedef logic [OFF_W-1:0]        off_t;
  typedef logic signed [DEC_W-1:0] dec_t;
  typedef logic [DIM_W-1:0]        dim_t;
  typedef logic [IDX_W-1:0]        idx_t;

  // input operation codes
  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  // configuration register indexes
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  localparam dim_t WIDTH_RESET  = 13'd800;
  localparam dim_t HEIGHT_RESET = 13'd600;

  // second-order midpoint constants
  localparam int DECISION_BASE   = 1;
  localparam int EAST_DELTA_INIT = 3;
  localparam int SE_DELTA_BASE   = 5;
  localparam int DELTA_STEP      = 2;
  localparam int SE_DELTA_STEP   = 4;

  localparam idx_t LAST_POINT = 3'd7;

  // pending point job from the stepper to the point unit
  typedef struct packed {
    logic valid;
    logic done;
  } job_t;

endpackage

/* design/mpcr_in_if.sv */
// command channel: start or step items
interface mpcr_in_if #(
  parameter int COORD_BITS = mpcr_pkg::COORD_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic signed [COORD_BITS-1:0]   center_x;
  logic signed [COORD_BITS-1:0]   center_y;
  logic [mpcr_pkg::RAD_W-1:0]     radius;
  logic [mpcr_pkg::COLOR_W-1:0]   draw_color;

  modport source (
    output valid, operation, center_x, center_y, radius, draw_color,
    input  ready
  );
  modport sink (
    input  valid, operation, center_x, center_y, radius, draw_color,
    output ready
  );
endinterface

/* design/mpcr_out_if.sv */
// point channel: one screen point per item
interface mpcr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mpcr_pkg::SCR_W-1:0]   screen_x;
  logic signed [mpcr_pkg::SCR_W-1:0]   screen_y;
  logic                                visible;
  logic [mpcr_pkg::COLOR_W-1:0]        pixel_color;
  logic                                last_of_step;
  logic                                circle_done;

  modport source (
    output valid, screen_x, screen_y, visible, pixel_color, last_of_step, circle_done,
    input  ready
  );
  modport sink (
    input  valid, screen_x, screen_y, visible, pixel_color, last_of_step, circle_done,
    output ready
  );
endinterface

/* design/mpcr_stepper.sv */
// circle state and second-order decision update, one step per accepted step
module mpcr_stepper #(
  parameter int COORD_BITS = mpcr_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  mpcr_in_if.sink                       cmd,
  input  logic                          release_job,
  output mpcr_pkg::job_t                job,
  output mpcr_pkg::off_t                job_a,
  output mpcr_pkg::off_t                job_b,
  output logic signed [COORD_BITS-1:0]  stored_center_x,
  output logic signed [COORD_BITS-1:0]  stored_center_y,
  output logic [mpcr_pkg::COLOR_W-1:0]  stored_color
);

  logic           circle_active;
  mpcr_pkg::off_t column_offset;
  mpcr_pkg::off_t row_offset;
  mpcr_pkg::dec_t decision;
  mpcr_pkg::dec_t east_delta;
  mpcr_pkg::dec_t southeast_delta;

  logic           accept;
  logic           is_step;
  logic           emit;
  logic           go_east;
  mpcr_pkg::off_t row_next;
  mpcr_pkg::off_t column_next;
  mpcr_pkg::dec_t radius_ext;
  logic           done_next;

  // a new job may enter once the pending one hands out its last point
  assign cmd.ready = !job.valid || release_job;
  assign accept    = cmd.valid && cmd.ready;
  assign is_step   = cmd.operation == mpcr_pkg::OP_STEP;
  assign emit      = accept && is_step && circle_active && (column_offset < row_offset);

  // east or south-east move
  always_comb begin
    go_east     = decision[mpcr_pkg::DEC_W-1];
    row_next    = go_east ? row_offset : row_offset - mpcr_pkg::off_t'(1);
    column_next = column_offset + mpcr_pkg::off_t'(1);
    done_next   = !(column_next < row_next);
    radius_ext  = mpcr_pkg::dec_t'(cmd.radius);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      circle_active <= 1'b0;
      job.valid     <= 1'b0;
      job.done      <= 1'b0;
    end else begin
      if (accept && !is_step) begin
        circle_active <= 1'b1;
      end else if (accept) begin
        circle_active <= emit && !done_next;
      end
      if (emit) begin
        job.valid <= 1'b1;
        job.done  <= done_next;
      end else if (release_job) begin
        job.valid <= 1'b0;
      end
    end
  end

  // circle state and job payload
  always_ff @(posedge clk) begin
    if (accept && !is_step) begin
      stored_center_x <= cmd.center_x;
      stored_center_y <= cmd.center_y;
      stored_color    <= cmd.draw_color;
      column_offset   <= '0;
      row_offset      <= mpcr_pkg::off_t'(cmd.radius);
      decision        <= mpcr_pkg::dec_t'(mpcr_pkg::DECISION_BASE) - radius_ext;
      east_delta      <= mpcr_pkg::dec_t'(mpcr_pkg::EAST_DELTA_INIT);
      southeast_delta <= mpcr_pkg::dec_t'(mpcr_pkg::SE_DELTA_BASE) - radius_ext - radius_ext;
    end else if (emit) begin
      decision        <= decision + (go_east ? east_delta : southeast_delta);
      east_delta      <= east_delta + mpcr_pkg::dec_t'(mpcr_pkg::DELTA_STEP);
      southeast_delta <= southeast_delta + (go_east ?
                           mpcr_pkg::dec_t'(mpcr_pkg::DELTA_STEP) :
                           mpcr_pkg::dec_t'(mpcr_pkg::SE_DELTA_STEP));
      row_offset      <= row_next;
      column_offset   <= column_next;
      job_a           <= column_offset;
      job_b           <= row_next;
    end
  end

  // a start always arms the circle
  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    accept && !is_step |=> circle_active)
    else $error("start item did not arm the circle");

  // a step with no active circle leaves no job behind
  a_idle_step_no_job: assert property (@(posedge clk) disable iff (rst)
    accept && is_step && !circle_active |=> !job.valid)
    else $error("step without active circle produced a job");

endmodule

/* design/mpcr_point.sv */
// eight-way symmetry, screen mapping, clipping and the output register
module mpcr_point #(
  parameter int COORD_BITS = mpcr_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mpcr_pkg::job_t                job,
  input  mpcr_pkg::off_t                job_a,
  input  mpcr_pkg::off_t                job_b,
  input  logic signed [COORD_BITS-1:0]  center_x,
  input  logic signed [COORD_BITS-1:0]  center_y,
  input  logic [mpcr_pkg::COLOR_W-1:0]  color,
  input  mpcr_pkg::dim_t                screen_width,
  input  mpcr_pkg::dim_t                screen_height,
  output logic                          release_job,
  mpcr_out_if.source                    pix
);

  localparam int SUM_W =
    ((COORD_BITS > mpcr_pkg::DIM_W) ? COORD_BITS : mpcr_pkg::DIM_W) + 3;

  mpcr_pkg::idx_t idx;

  logic                    advance;
  logic                    fire;
  logic                    is_last;
  mpcr_pkg::off_t          px_mag;
  mpcr_pkg::off_t          py_mag;
  logic                    px_neg;
  logic                    py_neg;
  logic signed [SUM_W-1:0] px;
  logic signed [SUM_W-1:0] py;
  logic signed [SUM_W-1:0] sx;
  logic signed [SUM_W-1:0] sy;
  logic signed [SUM_W-1:0] w_s;
  logic signed [SUM_W-1:0] h_s;
  logic                    vis;

  assign advance     = !pix.valid || pix.ready;
  assign fire        = job.valid && advance;
  assign is_last     = idx == mpcr_pkg::LAST_POINT;
  assign release_job = fire && is_last;

  // symmetric point selection in output order
  always_comb begin
    case (idx)
      3'd0:    begin px_mag = job_a; py_mag = job_b; px_neg = 1'b0; py_neg = 1'b0; end
      3'd1:    begin px_mag = job_b; py_mag = job_a; px_neg = 1'b0; py_neg = 1'b0; end
      3'd2:    begin px_mag = job_b; py_mag = job_a; px_neg = 1'b0; py_neg = 1'b1; end
      3'd3:    begin px_mag = job_a; py_mag = job_b; px_neg = 1'b0; py_neg = 1'b1; end
      3'd4:    begin px_mag = job_a; py_mag = job_b; px_neg = 1'b1; py_neg = 1'b1; end
      3'd5:    begin px_mag = job_b; py_mag = job_a; px_neg = 1'b1; py_neg = 1'b1; end
      3'd6:    begin px_mag = job_b; py_mag = job_a; px_neg = 1'b1; py_neg = 1'b0; end
      default: begin px_mag = job_a; py_mag = job_b; px_neg = 1'b1; py_neg = 1'b0; end
    endcase
  end

  // centered to screen coordinates and strict clip test
  always_comb begin
    px  = px_neg ? -$signed(SUM_W'(px_mag)) : $signed(SUM_W'(px_mag));
    py  = py_neg ? -$signed(SUM_W'(py_mag)) : $signed(SUM_W'(py_mag));
    w_s = $signed(SUM_W'(screen_width));
    h_s = $signed(SUM_W'(screen_height));
    sx  = SUM_W'(center_x) + px + $signed(SUM_W'(screen_width >> 1));
    sy  = $signed(SUM_W'(screen_height >> 1)) - (SUM_W'(center_y) + py);
    vis = !sx[SUM_W-1] && (sx != '0) && !sy[SUM_W-1] && (sy != '0) &&
          (sx < w_s) && (sy < h_s);
  end

  // point counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      pix.valid <= 1'b0;
    end else begin
      if (fire) begin
        idx <= idx + mpcr_pkg::idx_t'(1);
      end
      if (fire) begin
        pix.valid <= 1'b1;
      end else if (pix.ready) begin
        pix.valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (fire) begin
      pix.screen_x     <= sx[mpcr_pkg::SCR_W-1:0];
      pix.screen_y     <= sy[mpcr_pkg::SCR_W-1:0];
      pix.visible      <= vis;
      pix.pixel_color  <= color;
      pix.last_of_step <= is_last;
      pix.circle_done  <= is_last && job.done;
    end
  end

  // counter rests at the first point between jobs
  a_idx_idle: assert property (@(posedge clk) disable iff (rst)
    !job.valid |-> idx == '0)
    else $error("point counter not at start while no job pending");

  // the eighth point lands in the output register flagged last
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    release_job |=> pix.valid && pix.last_of_step)
    else $error("eighth point not flagged as last of step");

endmodule

/* design/midpoint_circle_rasterizer.sv */
// top level of the midpoint circle rasterizer with screen mapping and clipping
//
// cmd carries start items (operation 0: center, radius, color) and step items
// (operation 1). A start loads the circle and gives no point. A step advances
// the second-order midpoint decision by one column and gives the eight
// symmetric points of that column on pix, one item per cycle unless pix
// stalls, in the order (a,b) (b,a) (b,-a) (a,-b) (-a,-b) (-b,-a) (-b,a)
// (-a,b); the eighth carries last_of_step, and circle_done when the octant
// is finished. Steps after the octant ends, or with no circle loaded, give
// nothing. The first point of a step passes the job register and then the
// output register before it is valid on pix. The next item is accepted in
// the cycle the eighth point enters the output register; start items and
// empty steps leave no job pending. The user must write screen_width
// (index 0) and screen_height (index 1) through cfg_we/cfg_index/cfg_wdata
// only while the block is idle; the block itself does not enforce it. Reset
// clears the circle and the output valid and sets the frame to 800 by 600.
// When pix stalls, the output register holds its point and cmd.ready drops
// once a step is pending.
module midpoint_circle_rasterizer #(
  parameter int COORD_BITS = mpcr_pkg::COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  mpcr_in_if.sink                   cmd,
  mpcr_out_if.source                pix,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [mpcr_pkg::DIM_W-1:0] cfg_wdata
);

  mpcr_pkg::dim_t screen_width;
  mpcr_pkg::dim_t screen_height;

  mpcr_pkg::job_t               job;
  mpcr_pkg::off_t               job_a;
  mpcr_pkg::off_t               job_b;
  logic signed [COORD_BITS-1:0] stored_center_x;
  logic signed [COORD_BITS-1:0] stored_center_y;
  logic [mpcr_pkg::COLOR_W-1:0] stored_color;
  logic                         release_job;

  // frame size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= mpcr_pkg::WIDTH_RESET;
      screen_height <= mpcr_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mpcr_pkg::REG_WIDTH:  screen_width  <= cfg_wdata;
        mpcr_pkg::REG_HEIGHT: screen_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // decision stepper
  mpcr_stepper #(
    .COORD_BITS (COORD_BITS)
  ) u_stepper (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .release_job     (release_job),
    .job             (job),
    .job_a           (job_a),
    .job_b           (job_b),
    .stored_center_x (stored_center_x),
    .stored_center_y (stored_center_y),
    .stored_color    (stored_color)
  );

  // point generator and output register
  mpcr_point #(
    .COORD_BITS (COORD_BITS)
  ) u_point (
    .clk           (clk),
    .rst           (rst),
    .job           (job),
    .job_a         (job_a),
    .job_b         (job_b),
    .center_x      (stored_center_x),
    .center_y      (stored_center_y),
    .color         (stored_color),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .release_job   (release_job),
    .pix           (pix)
  );

endmodule

/* dv/mpcr_checker.sv */
// point predictor and checker for the midpoint circle rasterizer
module mpcr_checker (
  input  logic                       clk,
  input  logic                       rst,
  mpcr_in_if                         cmd,
  mpcr_out_if                        pix,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [mpcr_pkg::DIM_W-1:0] cfg_wdata,
  output int                         mismatches,
  output int                         points_pending,
  output int                         points_checked,
  output int                         octants_finished
);
  timeunit 1ns;
  timeprecision 1ps;
  import mpcr_pkg::*;

  typedef struct packed {
    logic signed [SCR_W-1:0] screen_x;
    logic signed [SCR_W-1:0] screen_y;
    logic                    visible;
    logic [COLOR_W-1:0]      pixel_color;
    logic                    last_of_step;
    logic                    circle_done;
  } point_t;

  point_t expected_points[$];

  // predicted block state
  dim_t                    frame_w;
  dim_t                    frame_h;
  off_t                    column;
  off_t                    row;
  dec_t                    decision;
  dec_t                    east_delta;
  dec_t                    southeast_delta;
  logic signed [OFF_W-1:0] center_x;
  logic signed [OFF_W-1:0] center_y;
  logic [COLOR_W-1:0]      color;
  logic                    active;

  // centered coordinates to screen coordinates with strict clipping
  function automatic point_t map_point(int px, int py, logic last, logic done);
    point_t p;
    int     sx;
    int     sy;
    int     w;
    int     h;
    w = int'(frame_w);
    h = int'(frame_h);
    sx = px + w / 2;
    sy = h / 2 - py;
    p.screen_x     = sx[SCR_W-1:0];
    p.screen_y     = sy[SCR_W-1:0];
    p.visible      = (sx > 0) && (sy > 0) && (sx < w) && (sy < h);
    p.pixel_color  = color;
    p.last_of_step = last;
    p.circle_done  = last && done;
    return p;
  endfunction

  // load a new circle and set up the second-order decision terms
  task automatic load_circle();
    center_x        = cmd.center_x;
    center_y        = cmd.center_y;
    color           = cmd.draw_color;
    decision        = dec_t'(DECISION_BASE - int'(cmd.radius));
    southeast_delta = dec_t'(SE_DELTA_BASE - 2 * int'(cmd.radius));
    east_delta      = dec_t'(EAST_DELTA_INIT);
    row             = off_t'(cmd.radius);
    column          = '0;
    active          = 1'b1;
  endtask

  // one midpoint iteration, queues the eight mirrored points
  task automatic step_circle();
    int   a;
    int   b;
    int   cx;
    int   cy;
    logic done;
    int   px [8];
    int   py [8];
    if (!active || !(column < row)) begin
      active = 1'b0;
      return;
    end
    if (decision < 0) begin
      decision        = decision + east_delta;
      east_delta      = east_delta + dec_t'(DELTA_STEP);
      southeast_delta = southeast_delta + dec_t'(DELTA_STEP);
    end else begin
      decision        = decision + southeast_delta;
      east_delta      = east_delta + dec_t'(DELTA_STEP);
      southeast_delta = southeast_delta + dec_t'(SE_DELTA_STEP);
      row             = row - 1'b1;
    end
    a = int'(column);
    b = int'(row);
    column = column + 1'b1;
    done = !(column < row);
    if (done) active = 1'b0;
    cx = int'(center_x);
    cy = int'(center_y);
    px = '{cx + a, cx + b, cx + b, cx + a, cx - a, cx - b, cx - b, cx - a};
    py = '{cy + b, cy + a, cy - a, cy - b, cy - b, cy - a, cy + a, cy + b};
    for (int k = 0; k < 8; k++) begin
      expected_points.push_back(map_point(px[k], py[k], idx_t'(k) == LAST_POINT, done));
    end
  endtask

  // compare one point from the block with the oldest prediction
  task automatic compare_point();
    point_t got;
    point_t want;
    got.screen_x     = pix.screen_x;
    got.screen_y     = pix.screen_y;
    got.visible      = pix.visible;
    got.pixel_color  = pix.pixel_color;
    got.last_of_step = pix.last_of_step;
    got.circle_done  = pix.circle_done;
    if (expected_points.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: unexpected point x=%0d y=%0d vis=%0b color=%h last=%0b done=%0b",
                 $realtime, got.screen_x, got.screen_y, got.visible, got.pixel_color,
                 got.last_of_step, got.circle_done);
      end
      return;
    end
    want = expected_points.pop_front();
    points_checked++;
    if (want.circle_done) octants_finished++;
    if (got.screen_x !== want.screen_x || got.screen_y !== want.screen_y ||
        got.visible !== want.visible || got.pixel_color !== want.pixel_color ||
        got.last_of_step !== want.last_of_step || got.circle_done !== want.circle_done) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: point mismatch", $realtime);
        $display("  expected x=%0d y=%0d vis=%0b color=%h last=%0b done=%0b",
                 want.screen_x, want.screen_y, want.visible, want.pixel_color,
                 want.last_of_step, want.circle_done);
        $display("  actual   x=%0d y=%0d vis=%0b color=%h last=%0b done=%0b",
                 got.screen_x, got.screen_y, got.visible, got.pixel_color,
                 got.last_of_step, got.circle_done);
      end
    end
  endtask

  // watch configuration, item and point handshakes
  always @(posedge clk) begin
    if (rst) begin
      frame_w          = WIDTH_RESET;
      frame_h          = HEIGHT_RESET;
      column           = '0;
      row              = '0;
      decision         = '0;
      east_delta       = '0;
      southeast_delta  = '0;
      center_x         = '0;
      center_y         = '0;
      color            = '0;
      active           = 1'b0;
      mismatches       = 0;
      points_checked   = 0;
      octants_finished = 0;
      expected_points.delete();
    end else begin
      if (cfg_we) begin
        if (reg_idx_t'(cfg_index) == REG_WIDTH) frame_w = cfg_wdata;
        else frame_h = cfg_wdata;
      end
      if (pix.valid && pix.ready) compare_point();
      if (cmd.valid && cmd.ready) begin
        if (op_t'(cmd.operation) == OP_START) load_circle();
        else step_circle();
      end
    end
    points_pending = expected_points.size();
  end

endmodule

/* dv/tb_midpoint_circle_rasterizer.sv */
// top level testbench: circle and step stimulus, frame settings and verdict
module tb_midpoint_circle_rasterizer;
  timeunit 1ns;
  timeprecision 1ps;
  import mpcr_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 160;
  localparam int PHASES       = 7;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  dim_t cfg_wdata;

  int mismatches;
  int points_pending;
  int points_checked;
  int octants_finished;
  int items_sent;
  int starts_sent;
  int frames_used;
  int burst_left;
  int idle_cycles;

  mpcr_in_if  cmd_ch ();
  mpcr_out_if pix_ch ();

  midpoint_circle_rasterizer DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .pix       (pix_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  mpcr_checker point_check (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd_ch),
    .pix              (pix_ch),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .mismatches       (mismatches),
    .points_pending   (points_pending),
    .points_checked   (points_checked),
    .octants_finished (octants_finished)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // point receiver: switches among four random stall patterns
  initial begin
    int mode;
    int mode_left;
    int hold;
    mode = 0;
    mode_left = 0;
    hold = 0;
    pix_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      case (mode)
        0: pix_ch.ready <= 1'b1;
        1: pix_ch.ready <= 1'($urandom_range(0, 1));
        2: pix_ch.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          // long stalls with single open cycles
          if (hold == 0) hold = $urandom_range(1, 12);
          hold--;
          pix_ch.ready <= (hold == 0);
        end
      endcase
    end
  end

  // watchdog on cycles where no item moves
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (pix_ch.valid && pix_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // send one item, in bursts separated by random gaps
  task automatic send_item(op_t op, logic signed [11:0] cx, logic signed [11:0] cy,
                           logic [RAD_W-1:0] r, logic [COLOR_W-1:0] argb);
    if (burst_left == 0) begin
      @(negedge clk);
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    cmd_ch.valid      <= 1'b1;
    cmd_ch.operation  <= op;
    cmd_ch.center_x   <= cx;
    cmd_ch.center_y   <= cy;
    cmd_ch.radius     <= r;
    cmd_ch.draw_color <= argb;
    items_sent++;
    if (op == OP_START) starts_sent++;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  // step item with junk in the unused fields
  task automatic send_step();
    send_item(OP_STEP, 12'($urandom), 12'($urandom), 11'($urandom), $urandom);
  endtask

  // hold the sender until every predicted point has come out
  task automatic drain();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    burst_left = 0;
    while (points_pending != 0) @(negedge clk);
    // an empty step may still be in flight
    repeat (4) @(negedge clk);
  endtask

  // write both frame registers
  task automatic set_frame(dim_t w, dim_t h);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_wdata <= h;
    @(negedge clk);
    cfg_we <= 1'b0;
    frames_used++;
  endtask

  // one circle: mostly a full octant plus a step or two past the end,
  // sometimes cut short by the next start
  task automatic random_circle(inout int budget);
    int                r;
    int                steps;
    logic signed [11:0] cx;
    logic signed [11:0] cy;
    if ($urandom_range(0, 15) == 0) drain();
    case ($urandom_range(0, 9))
      0:       r = 0;
      1, 2:    r = $urandom_range(0, 2047);
      default: r = $urandom_range(1, 16);
    endcase
    if ($urandom_range(0, 1) == 1) begin
      cx = 12'($urandom);
      cy = 12'($urandom);
    end else begin
      cx = 12'(int'($urandom_range(0, 400)) - 200);
      cy = 12'(int'($urandom_range(0, 400)) - 200);
    end
    if (r > 16) steps = $urandom_range(2, 8);
    else if ($urandom_range(0, 4) == 0) steps = $urandom_range(0, 4);
    else steps = (r * 3) / 4 + $urandom_range(0, 2);
    send_item(OP_START, cx, cy, 11'(r), $urandom);
    budget--;
    for (int i = 0; i < steps && budget > 0; i++) begin
      send_step();
      budget--;
    end
  endtask

  // stimulus and verdict
  initial begin
    int budget;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = REG_WIDTH;
    cfg_wdata         = '0;
    cmd_ch.valid      = 1'b0;
    cmd_ch.operation  = OP_START;
    cmd_ch.center_x   = '0;
    cmd_ch.center_y   = '0;
    cmd_ch.radius     = '0;
    cmd_ch.draw_color = '0;
    items_sent  = 0;
    starts_sent = 0;
    frames_used = 1;
    burst_left  = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // step with no circle loaded
    send_step();
    // extreme center, color and radius
    send_item(OP_START, 12'h800, 12'h7FF, 11'h7FF, 32'hFFFF_FFFF);
    send_step();
    send_step();
    // radius one ends in one step, then a step past the end
    send_item(OP_START, 12'h7FF, 12'h800, 11'd1, 32'h0000_0000);
    send_step();
    send_step();
    // zero radius gives an empty octant
    send_item(OP_START, 12'd0, 12'd0, 11'd0, 32'h1234_5678);
    send_step();
    // small circle touching the right and top frame edges
    send_item(OP_START, 12'd395, 12'd295, 11'd5, 32'h5A5A_A5A5);
    repeat (5) send_step();

    // random circles under several frame settings, extremes among them
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        drain();
        case (phase)
          1: set_frame(13'd1, 13'd0);
          2: set_frame(13'd8191, 13'd8191);
          3: set_frame(13'd0, 13'd1);
          4: set_frame(13'd4096, 13'd4096);
          5: set_frame(dim_t'($urandom_range(2, 8191)), dim_t'($urandom_range(2, 8191)));
          default: set_frame(13'd640, 13'd480);
        endcase
      end
      budget = RANDOM_ITEMS / PHASES;
      while (budget > 0) random_circle(budget);
    end

    drain();
    repeat (16) @(negedge clk);
    $display("covered %0d items (%0d circle starts) over %0d frame settings",
             items_sent, starts_sent, frames_used);
    $display("checked %0d points, %0d octants run to completion",
             points_checked, octants_finished);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
